[src/dcdc_charger_controller_core_defines.svh]
// ---------------------------------------------------------------------------
// dcdc_charger_controller_core_defines.svh
// Assertion macros shared by the charger controller RTL.
// ---------------------------------------------------------------------------
`ifndef DCDC_CHARGER_CONTROLLER_CORE_DEFINES_SVH
`define DCDC_CHARGER_CONTROLLER_CORE_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define DCDC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that must also hold during reset.
`define DCDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dcdc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcdc_pkg
// Types, codes and constants of the DC-DC charger controller.
// ---------------------------------------------------------------------------
package dcdc_pkg;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 2;
    localparam int CURRENT_W = 18;
    localparam int VOLT_W    = 15;
    localparam int MARGIN_W  = 12;
    localparam int SECONDS_W = 12;
    localparam int STATE_W   = 2;
    localparam int DELAY_W   = 22;

    // Configuration port.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_VOLTAGE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF        = 3'd4;

    localparam logic [MARGIN_W-1:0]  DEAD_ZONE_RESET      = 12'd100;
    localparam logic [VOLT_W-1:0]    SLOW_THRESHOLD_RESET = 15'd12200;
    localparam logic [MARGIN_W-1:0]  HYSTERESIS_RESET     = 12'd300;
    localparam logic [VOLT_W-1:0]    FULL_VOLTAGE_RESET   = 15'd14400;
    localparam logic [SECONDS_W-1:0] HOLDOFF_RESET        = 12'd30;

    // Charge mode codes.
    localparam logic [MODE_W-1:0] MODE_DISABLED    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORCED_SLOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO        = 2'd2;

    // Reported controller state codes.
    localparam logic [STATE_W-1:0] CTRL_IDLE     = 2'd0;
    localparam logic [STATE_W-1:0] CTRL_ALT_ON   = 2'd1;
    localparam logic [STATE_W-1:0] CTRL_CHARGING = 2'd2;

    // Thresholds and timing.
    localparam logic signed [CURRENT_W-1:0] ALT_ON_MA    = 18'sd1000;
    localparam logic signed [CURRENT_W-1:0] FULL_RATE_MA = -18'sd5000;
    localparam logic [VOLT_W-1:0]           FULL_LOW_MV  = 15'd13400;
    localparam logic [TIME_W-1:0]           GRACE_MS     = 32'd10000;
    localparam logic [TIME_W-1:0]           SLOW_DWELL_MS = 32'd300000;
    localparam logic [DELAY_W-1:0]          MS_PER_SECOND = 22'd1000;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_ALT_ON   = 3'b010,
        ST_CHARGING = 3'b100
    } ctrl_state_t;

endpackage

[src/dcdc_interfaces.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcdc_interfaces
// Valid/ready channels for ticks into and results out of the controller.
// ---------------------------------------------------------------------------
interface dcdc_tick_if;
    logic                                       valid;
    logic                                       ready;
    logic [dcdc_pkg::TIME_W-1:0]                now_ms;
    logic [dcdc_pkg::MODE_W-1:0]                charge_mode;
    logic signed [dcdc_pkg::CURRENT_W-1:0]      alternator_current_ma;
    logic [dcdc_pkg::VOLT_W-1:0]                starter_mv;
    logic [dcdc_pkg::VOLT_W-1:0]                house_mv;
    logic signed [dcdc_pkg::CURRENT_W-1:0]      house_current_ma;

    modport source (
        output valid, now_ms, charge_mode, alternator_current_ma,
               starter_mv, house_mv, house_current_ma,
        input  ready
    );
    modport sink (
        input  valid, now_ms, charge_mode, alternator_current_ma,
               starter_mv, house_mv, house_current_ma,
        output ready
    );
endinterface

interface dcdc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          charger_enable;
    logic                          slow_charge;
    logic [dcdc_pkg::STATE_W-1:0]  ctrl_state;
    logic                          selector_both;
    logic                          fully_charged;

    modport source (
        output valid, charger_enable, slow_charge, ctrl_state,
               selector_both, fully_charged,
        input  ready
    );
    modport sink (
        input  valid, charger_enable, slow_charge, ctrl_state,
               selector_both, fully_charged,
        output ready
    );
endinterface

[src/dcdc_charger_controller_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcdc_charger_controller_core
// Charger state machine, holdoff timer, selector detection and slow/fast
// relay choice, evaluated once per tick request.
// ---------------------------------------------------------------------------
// Flow: a tick request is accepted into the input register and evaluated into
// the result register when that register is free or drains.
// Throughput: one tick per cycle while results drain; the state update is a
// single pass of compare and select logic between input and result registers.
// Reset: asynchronous; the machine returns to idle, all flags and timers clear
// and the configuration registers take their default values.
`include "dcdc_charger_controller_core_defines.svh"

module dcdc_charger_controller_core (
    input  logic                              clk,
    input  logic                              rst_n,
    dcdc_tick_if.sink                         tick,
    dcdc_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcdc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dcdc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dcdc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // Configuration registers.
    logic [dcdc_pkg::MARGIN_W-1:0]  dead_zone_reg;
    logic [dcdc_pkg::VOLT_W-1:0]    slow_threshold_reg;
    logic [dcdc_pkg::MARGIN_W-1:0]  hysteresis_reg;
    logic [dcdc_pkg::VOLT_W-1:0]    full_voltage_reg;
    logic [dcdc_pkg::SECONDS_W-1:0] holdoff_seconds_reg;

    logic                             cfg_write;
    logic [dcdc_pkg::CFG_INDEX_W-1:0] cfg_index;

    // Input register.
    logic                                  tick_valid_reg;
    logic [dcdc_pkg::TIME_W-1:0]           now_reg;
    logic [dcdc_pkg::MODE_W-1:0]           mode_reg;
    logic signed [dcdc_pkg::CURRENT_W-1:0] alt_ma_reg;
    logic [dcdc_pkg::VOLT_W-1:0]           starter_reg;
    logic [dcdc_pkg::VOLT_W-1:0]           house_reg;
    logic signed [dcdc_pkg::CURRENT_W-1:0] house_ma_reg;

    // Controller state.
    dcdc_pkg::ctrl_state_t          state_reg, state_next;
    logic                           alt_running_reg, alt_running_next;
    logic                           forced_slow_reg, forced_slow_next;
    logic                           slow_active_reg, slow_active_next;
    logic [dcdc_pkg::TIME_W-1:0]    slow_since_reg, slow_since_next;
    logic                           full_seen_reg, full_seen_next;
    logic                           holdoff_run_reg, holdoff_run_next;
    logic [dcdc_pkg::TIME_W-1:0]    holdoff_start_reg, holdoff_start_next;
    logic [dcdc_pkg::DELAY_W-1:0]   holdoff_delay_reg, holdoff_delay_next;
    logic                           joined_seen_reg, joined_seen_next;
    logic [dcdc_pkg::TIME_W-1:0]    joined_since_reg, joined_since_next;
    logic                           selector_reg, selector_next;
    logic                           enable_reg, enable_next;

    // Result register.
    logic                           res_valid_reg;
    logic [dcdc_pkg::STATE_W-1:0]   res_state_reg;
    logic                           res_enable_reg;
    logic                           res_slow_reg;
    logic                           res_selector_reg;
    logic                           res_full_reg;
    logic [dcdc_pkg::STATE_W-1:0]   state_code;

    logic                           advance;
    logic                           skip;
    logic                           joined_cond;
    logic [dcdc_pkg::VOLT_W-1:0]    volt_diff;
    logic [dcdc_pkg::VOLT_W:0]      fast_level;
    logic [dcdc_pkg::DELAY_W-1:0]   delay_capture;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[dcdc_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg       <= dcdc_pkg::DEAD_ZONE_RESET;
            slow_threshold_reg  <= dcdc_pkg::SLOW_THRESHOLD_RESET;
            hysteresis_reg      <= dcdc_pkg::HYSTERESIS_RESET;
            full_voltage_reg    <= dcdc_pkg::FULL_VOLTAGE_RESET;
            holdoff_seconds_reg <= dcdc_pkg::HOLDOFF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dcdc_pkg::REG_DEAD_ZONE:
                    dead_zone_reg <= pwdata[dcdc_pkg::MARGIN_W-1:0];
                dcdc_pkg::REG_SLOW_THRESHOLD:
                    slow_threshold_reg <= pwdata[dcdc_pkg::VOLT_W-1:0];
                dcdc_pkg::REG_HYSTERESIS:
                    hysteresis_reg <= pwdata[dcdc_pkg::MARGIN_W-1:0];
                dcdc_pkg::REG_FULL_VOLTAGE:
                    full_voltage_reg <= pwdata[dcdc_pkg::VOLT_W-1:0];
                dcdc_pkg::REG_HOLDOFF:
                    holdoff_seconds_reg <= pwdata[dcdc_pkg::SECONDS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            dcdc_pkg::REG_DEAD_ZONE:
                prdata = dcdc_pkg::CFG_DATA_W'(dead_zone_reg);
            dcdc_pkg::REG_SLOW_THRESHOLD:
                prdata = dcdc_pkg::CFG_DATA_W'(slow_threshold_reg);
            dcdc_pkg::REG_HYSTERESIS:
                prdata = dcdc_pkg::CFG_DATA_W'(hysteresis_reg);
            dcdc_pkg::REG_FULL_VOLTAGE:
                prdata = dcdc_pkg::CFG_DATA_W'(full_voltage_reg);
            dcdc_pkg::REG_HOLDOFF:
                prdata = dcdc_pkg::CFG_DATA_W'(holdoff_seconds_reg);
            default:
                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // The held tick moves on whenever the result register is free or drains.
    assign advance    = tick_valid_reg && (!res_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            now_reg      <= tick.now_ms;
            mode_reg     <= tick.charge_mode;
            alt_ma_reg   <= tick.alternator_current_ma;
            starter_reg  <= tick.starter_mv;
            house_reg    <= tick.house_mv;
            house_ma_reg <= tick.house_current_ma;
        end
    end

    // ---------------- tick evaluation ----------------
    assign volt_diff = (starter_reg > house_reg) ? (starter_reg - house_reg)
                                                 : (house_reg - starter_reg);
    assign fast_level = {1'b0, slow_threshold_reg}
                        + (dcdc_pkg::VOLT_W + 1)'(hysteresis_reg);
    assign delay_capture = dcdc_pkg::DELAY_W'(holdoff_seconds_reg) * dcdc_pkg::MS_PER_SECOND;

    always_comb
    begin
        state_next         = state_reg;
        alt_running_next   = alt_running_reg;
        forced_slow_next   = forced_slow_reg;
        slow_active_next   = slow_active_reg;
        slow_since_next    = slow_since_reg;
        full_seen_next     = full_seen_reg;
        holdoff_run_next   = holdoff_run_reg;
        holdoff_start_next = holdoff_start_reg;
        holdoff_delay_next = holdoff_delay_reg;
        joined_seen_next   = joined_seen_reg;
        joined_since_next  = joined_since_reg;
        selector_next      = selector_reg;
        enable_next        = enable_reg;
        skip               = 1'b0;
        joined_cond        = 1'b0;

        // Holdoff expiry, with wrapping elapsed time.
        if (holdoff_run_reg &&
            (now_reg - holdoff_start_reg) >= dcdc_pkg::TIME_W'(holdoff_delay_reg))
        begin
            holdoff_run_next = 1'b0;
            if (state_next == dcdc_pkg::ST_ALT_ON)
            begin
                state_next       = dcdc_pkg::ST_CHARGING;
                slow_active_next = 1'b0;
                full_seen_next   = 1'b0;
                enable_next      = 1'b1;
            end
        end

        case (mode_reg)
            dcdc_pkg::MODE_DISABLED:
            begin
                if (state_next == dcdc_pkg::ST_CHARGING)
                begin
                    state_next       = dcdc_pkg::ST_IDLE;
                    holdoff_run_next = 1'b0;
                    enable_next      = 1'b0;
                end
                skip = 1'b1;
            end
            dcdc_pkg::MODE_FORCED_SLOW, dcdc_pkg::MODE_AUTO:
            begin
                forced_slow_next = (mode_reg == dcdc_pkg::MODE_FORCED_SLOW);
                if (state_next != dcdc_pkg::ST_CHARGING)
                begin
                    alt_running_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (!skip)
        begin
            // Alternator on/off edges.
            if (alt_ma_reg > dcdc_pkg::ALT_ON_MA)
            begin
                if (!alt_running_next)
                begin
                    if (state_next == dcdc_pkg::ST_IDLE)
                    begin
                        state_next = dcdc_pkg::ST_ALT_ON;
                        if (!holdoff_run_next)
                        begin
                            holdoff_run_next   = 1'b1;
                            holdoff_start_next = now_reg;
                            holdoff_delay_next = delay_capture;
                        end
                    end
                    alt_running_next = 1'b1;
                end
            end
            else if (alt_running_next)
            begin
                if (state_next == dcdc_pkg::ST_CHARGING)
                begin
                    state_next       = dcdc_pkg::ST_IDLE;
                    holdoff_run_next = 1'b0;
                    enable_next      = 1'b0;
                end
                alt_running_next = 1'b0;
            end

            // Banks joined when their voltages sit within the dead zone.
            if (volt_diff < dcdc_pkg::VOLT_W'(dead_zone_reg))
            begin
                if (!joined_seen_next)
                begin
                    joined_seen_next  = 1'b1;
                    joined_since_next = now_reg;
                end
            end
            else
            begin
                joined_seen_next = 1'b0;
            end

            // While charging, joined banks count only after the grace period and before full charge is seen.
            if (state_next != dcdc_pkg::ST_CHARGING)
            begin
                joined_cond = joined_seen_next;
            end
            else
            begin
                joined_cond = !full_seen_next && joined_seen_next &&
                              ((now_reg - joined_since_next) > dcdc_pkg::GRACE_MS);
            end

            if (joined_cond)
            begin
                if (state_next == dcdc_pkg::ST_ALT_ON)
                begin
                    state_next       = dcdc_pkg::ST_IDLE;
                    holdoff_run_next = 1'b0;
                    enable_next      = 1'b0;
                end
                selector_next = 1'b1;
            end
            else
            begin
                selector_next = 1'b0;
            end

            // Slow charge with hysteresis and a minimum dwell.
            if ((state_next == dcdc_pkg::ST_CHARGING && starter_reg < slow_threshold_reg)
                || forced_slow_next)
            begin
                if (!slow_active_next)
                begin
                    slow_active_next = 1'b1;
                    slow_since_next  = now_reg;
                end
            end
            else if (slow_active_next &&
                     ({1'b0, starter_reg} > fast_level) &&
                     ((now_reg - slow_since_next) > dcdc_pkg::SLOW_DWELL_MS))
            begin
                slow_active_next = 1'b0;
                slow_since_next  = '0;
            end

            if (state_next == dcdc_pkg::ST_CHARGING &&
                (house_reg > full_voltage_reg ||
                 (house_reg > dcdc_pkg::FULL_LOW_MV &&
                  house_ma_reg > dcdc_pkg::FULL_RATE_MA)))
            begin
                full_seen_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (state_next)
            dcdc_pkg::ST_IDLE:     state_code = dcdc_pkg::CTRL_IDLE;
            dcdc_pkg::ST_ALT_ON:   state_code = dcdc_pkg::CTRL_ALT_ON;
            dcdc_pkg::ST_CHARGING: state_code = dcdc_pkg::CTRL_CHARGING;
            default:               state_code = dcdc_pkg::CTRL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= dcdc_pkg::ST_IDLE;
            alt_running_reg   <= 1'b0;
            forced_slow_reg   <= 1'b0;
            slow_active_reg   <= 1'b0;
            slow_since_reg    <= '0;
            full_seen_reg     <= 1'b0;
            holdoff_run_reg   <= 1'b0;
            holdoff_start_reg <= '0;
            holdoff_delay_reg <= '0;
            joined_seen_reg   <= 1'b0;
            joined_since_reg  <= '0;
            selector_reg      <= 1'b0;
            enable_reg        <= 1'b0;
        end
        else if (advance)
        begin
            state_reg         <= state_next;
            alt_running_reg   <= alt_running_next;
            forced_slow_reg   <= forced_slow_next;
            slow_active_reg   <= slow_active_next;
            slow_since_reg    <= slow_since_next;
            full_seen_reg     <= full_seen_next;
            holdoff_run_reg   <= holdoff_run_next;
            holdoff_start_reg <= holdoff_start_next;
            holdoff_delay_reg <= holdoff_delay_next;
            joined_seen_reg   <= joined_seen_next;
            joined_since_reg  <= joined_since_next;
            selector_reg      <= selector_next;
            enable_reg        <= enable_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_state_reg    <= state_code;
            res_enable_reg   <= enable_next;
            res_slow_reg     <= slow_active_next;
            res_selector_reg <= selector_next;
            res_full_reg     <= full_seen_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.charger_enable = res_enable_reg;
    assign result.slow_charge    = res_slow_reg;
    assign result.ctrl_state     = res_state_reg;
    assign result.selector_both  = res_selector_reg;
    assign result.fully_charged  = res_full_reg;

    // ---------------- assertions ----------------
    // The enable relay is driven exactly while the machine is charging.
    `DCDC_ASSERT_ALWAYS(a_enable_tracks_charging, clk,
        enable_reg == (state_reg == dcdc_pkg::ST_CHARGING),
        "charger enable out of step with charging state")
    // Full charge is only ever flagged while charging.
    `DCDC_ASSERT_RST(a_full_only_charging, clk, rst_n,
        $rose(full_seen_reg) |-> state_reg == dcdc_pkg::ST_CHARGING,
        "full charge flagged outside charging")
    // Every evaluated tick lands in the result register.
    `DCDC_ASSERT_RST(a_advance_gives_result, clk, rst_n,
        advance |=> res_valid_reg,
        "evaluated tick produced no result")
    // A held tick that cannot move on stays in the input register.
    `DCDC_ASSERT_RST(a_tick_held, clk, rst_n,
        (tick_valid_reg && !advance) |=> tick_valid_reg && $stable(now_reg),
        "stalled tick lost from input register")

endmodule

[tb/dcdc_charger_controller_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcdc_charger_controller_core_test
// Drives tick requests into the charger controller and checks every result
// against a cycle-free model of the controller kept in this module, or a typed
// row's fixed status. A short table of hand-picked ticks runs first. Random
// phases with different settings follow, each written through APB while idle.
// ---------------------------------------------------------------------------
module dcdc_charger_controller_core_test;
    import dcdc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [TIME_W-1:0]           now_ms;
        logic [MODE_W-1:0]           charge_mode;
        logic signed [CURRENT_W-1:0] alternator_current_ma;
        logic [VOLT_W-1:0]           starter_mv;
        logic [VOLT_W-1:0]           house_mv;
        logic signed [CURRENT_W-1:0] house_current_ma;
    } tick_t;

    typedef struct packed {
        logic               charger_enable;
        logic               slow_charge;
        logic [STATE_W-1:0] ctrl_state;
        logic               selector_both;
        logic               fully_charged;
    } status_t;

    typedef struct {
        tick_t   t;
        bit      typed;
        status_t fixed;
    } tick_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    dcdc_tick_if   tick_ch ();
    dcdc_result_if status_ch ();

    dcdc_charger_controller_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .result  (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Controller copy: settings.
    logic [MARGIN_W-1:0]  cfg_dead_zone  = DEAD_ZONE_RESET;
    logic [VOLT_W-1:0]    cfg_threshold  = SLOW_THRESHOLD_RESET;
    logic [MARGIN_W-1:0]  cfg_hysteresis = HYSTERESIS_RESET;
    logic [VOLT_W-1:0]    cfg_full       = FULL_VOLTAGE_RESET;
    logic [SECONDS_W-1:0] cfg_holdoff    = HOLDOFF_RESET;

    // Controller copy: state.
    logic [STATE_W-1:0] ctrl_mode    = CTRL_IDLE;
    logic               alt_running  = 1'b0;
    logic               forced_slow  = 1'b0;
    logic               slow_on      = 1'b0;
    logic [TIME_W-1:0]  slow_since   = '0;
    logic               full_seen    = 1'b0;
    logic               hold_running = 1'b0;
    logic [TIME_W-1:0]  hold_start   = '0;
    logic [TIME_W-1:0]  hold_delay   = '0;
    logic               joined_seen  = 1'b0;
    logic [TIME_W-1:0]  joined_since = '0;
    logic               selector     = 1'b0;
    logic               relay_on     = 1'b0;

    status_t   status_due[$];
    tick_row_t directed_rows[$];
    int        status_errors = 0;
    int        burst_left = 0;
    status_t   got_status;
    status_t   want_status;

    // Stimulus generator state.
    logic [TIME_W-1:0] gen_now = '0;
    bit gen_alt = 1'b0;
    bit gen_joined = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t step_controller(input tick_t t);
        logic [TIME_W-1:0] elapsed;
        logic [VOLT_W-1:0] gap_mv;
        logic [31:0] fast_level;
        bit skip;
        bit cond;
        skip = 1'b0;
        elapsed = t.now_ms - hold_start;
        if (hold_running && elapsed >= hold_delay)
        begin
            hold_running = 1'b0;
            if (ctrl_mode == CTRL_ALT_ON)
            begin
                ctrl_mode = CTRL_CHARGING;
                slow_on = 1'b0;
                full_seen = 1'b0;
                relay_on = 1'b1;
            end
        end

        if (t.charge_mode == MODE_DISABLED)
        begin
            if (ctrl_mode == CTRL_CHARGING)
            begin
                ctrl_mode = CTRL_IDLE;
                hold_running = 1'b0;
                relay_on = 1'b0;
            end
            skip = 1'b1;
        end
        else if (t.charge_mode == MODE_FORCED_SLOW || t.charge_mode == MODE_AUTO)
        begin
            forced_slow = (t.charge_mode == MODE_FORCED_SLOW);
            // Outside a charge a running alternator has to be seen again.
            if (ctrl_mode != CTRL_CHARGING)
                alt_running = 1'b0;
        end

        if (!skip)
        begin
            if (int'(t.alternator_current_ma) > int'(ALT_ON_MA))
            begin
                if (!alt_running)
                begin
                    if (ctrl_mode == CTRL_IDLE)
                    begin
                        ctrl_mode = CTRL_ALT_ON;
                        if (!hold_running)
                        begin
                            hold_running = 1'b1;
                            hold_start = t.now_ms;
                            hold_delay = 32'(cfg_holdoff) * 32'(MS_PER_SECOND);
                        end
                    end
                    alt_running = 1'b1;
                end
            end
            else if (alt_running)
            begin
                if (ctrl_mode == CTRL_CHARGING)
                begin
                    ctrl_mode = CTRL_IDLE;
                    hold_running = 1'b0;
                    relay_on = 1'b0;
                end
                alt_running = 1'b0;
            end

            gap_mv = (t.starter_mv > t.house_mv) ? t.starter_mv - t.house_mv
                                                 : t.house_mv - t.starter_mv;
            if (32'(gap_mv) < 32'(cfg_dead_zone))
            begin
                if (!joined_seen)
                begin
                    joined_seen = 1'b1;
                    joined_since = t.now_ms;
                end
            end
            else
                joined_seen = 1'b0;

            elapsed = t.now_ms - joined_since;
            if (ctrl_mode != CTRL_CHARGING)
                cond = joined_seen;
            else
                cond = !full_seen && joined_seen && elapsed > GRACE_MS;
            if (cond)
            begin
                if (ctrl_mode == CTRL_ALT_ON)
                begin
                    ctrl_mode = CTRL_IDLE;
                    hold_running = 1'b0;
                    relay_on = 1'b0;
                end
                selector = 1'b1;
            end
            else
                selector = 1'b0;

            elapsed = t.now_ms - slow_since;
            fast_level = 32'(cfg_threshold) + 32'(cfg_hysteresis);
            if ((ctrl_mode == CTRL_CHARGING && t.starter_mv < cfg_threshold) || forced_slow)
            begin
                if (!slow_on)
                begin
                    slow_on = 1'b1;
                    slow_since = t.now_ms;
                end
            end
            else if (slow_on && 32'(t.starter_mv) > fast_level && elapsed > SLOW_DWELL_MS)
            begin
                slow_on = 1'b0;
                slow_since = '0;
            end

            if (ctrl_mode == CTRL_CHARGING &&
                (t.house_mv > cfg_full ||
                 (t.house_mv > FULL_LOW_MV &&
                  int'(t.house_current_ma) > int'(FULL_RATE_MA))))
                full_seen = 1'b1;
        end

        return status_t'{relay_on, slow_on, ctrl_mode, selector, full_seen};
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEAD_ZONE:      cfg_dead_zone  = value[MARGIN_W-1:0];
            REG_SLOW_THRESHOLD: cfg_threshold  = value[VOLT_W-1:0];
            REG_HYSTERESIS:     cfg_hysteresis = value[MARGIN_W-1:0];
            REG_FULL_VOLTAGE:   cfg_full       = value[VOLT_W-1:0];
            REG_HOLDOFF:        cfg_holdoff    = value[SECONDS_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all five registers; with junk set the unused upper bits carry noise.
    task automatic load_settings(input int dead_zone, input int threshold,
                                 input int hysteresis, input int full_mv,
                                 input int holdoff, input bit junk);
        logic [CFG_DATA_W-1:0] noise;
        noise = junk ? $urandom() : '0;
        write_register(REG_DEAD_ZONE,      {noise[31:12], 12'(dead_zone)});
        write_register(REG_SLOW_THRESHOLD, {noise[31:15], 15'(threshold)});
        write_register(REG_HYSTERESIS,     {~noise[31:12], 12'(hysteresis)});
        write_register(REG_FULL_VOLTAGE,   {~noise[31:15], 15'(full_mv)});
        write_register(REG_HOLDOFF,        {noise[31:12], 12'(holdoff)});
    endtask

    task automatic send_tick(input tick_t t, input bit typed, input status_t fixed);
        int gap;
        status_t outcome;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick_ch.valid                 <= 1'b1;
        tick_ch.now_ms                <= t.now_ms;
        tick_ch.charge_mode           <= t.charge_mode;
        tick_ch.alternator_current_ma <= t.alternator_current_ma;
        tick_ch.starter_mv            <= t.starter_mv;
        tick_ch.house_mv              <= t.house_mv;
        tick_ch.house_current_ma      <= t.house_current_ma;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        outcome = step_controller(t);
        status_due.push_back(typed ? fixed : outcome);
    endtask

    task automatic settle;
        tick_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int clamp_mv(input int v);
        if (v < 0)
            return 0;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic tick_t next_tick();
        tick_t t;
        int r;
        int starter;
        int house;
        r = $urandom_range(0, 999);
        if (r < 700)
            gen_now = gen_now + $urandom_range(200, 4000);
        else if (r < 900)
            gen_now = gen_now + $urandom_range(4000, 30000);
        else if (r < 980)
            gen_now = gen_now + $urandom_range(30000, 400000);
        else
            gen_now = $urandom();
        t.now_ms = gen_now;

        r = $urandom_range(0, 999);
        if (r < 15)
            t.charge_mode = MODE_DISABLED;
        else if (r < 30)
            t.charge_mode = MODE_UNUSED;
        else if (r < 160)
            t.charge_mode = MODE_FORCED_SLOW;
        else
            t.charge_mode = MODE_AUTO;

        // Alternator runs in long episodes so that charges last past the dwell.
        if (gen_alt)
            gen_alt = ($urandom_range(0, 119) != 0);
        else
            gen_alt = ($urandom_range(0, 14) == 0);
        if (gen_alt)
            t.alternator_current_ma = ($urandom_range(0, 9) == 0) ?
                18'($urandom_range(1001, 131071)) : 18'($urandom_range(1001, 60000));
        else
            t.alternator_current_ma = ($urandom_range(0, 4) == 0) ?
                18'($urandom()) : 18'(int'($urandom_range(0, 21000)) - 20000);

        if (gen_joined)
            gen_joined = ($urandom_range(0, 5) != 0);
        else
            gen_joined = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 6) == 0)
            starter = $urandom_range(0, 32767);
        else
            starter = clamp_mv(int'(cfg_threshold) + int'($urandom_range(0, 3000)) - 1500);
        if (gen_joined)
            house = clamp_mv(starter + int'($urandom_range(0, 2 * int'(cfg_dead_zone) + 20))
                             - int'(cfg_dead_zone) - 10);
        else if ($urandom_range(0, 6) == 0)
            house = $urandom_range(0, 32767);
        else
            house = $urandom_range(12000, 15000);
        t.starter_mv = 15'(starter);
        t.house_mv = 15'(house);

        t.house_current_ma = ($urandom_range(0, 1) == 0) ?
            18'(int'($urandom_range(0, 12000)) - 11000) : 18'($urandom());
        return t;
    endfunction

    task automatic run_phase(input int count);
        repeat (count) send_tick(next_tick(), 1'b0, '0);
        settle();
    endtask

    function automatic void add_row(input logic [TIME_W-1:0] now, input logic [MODE_W-1:0] mode,
                                    input int alt, input int starter, input int house,
                                    input int house_ma, input bit typed = 1'b0,
                                    input status_t fixed = '0);
        tick_row_t row;
        row.t = tick_t'{now, mode, 18'(alt), 15'(starter), 15'(house), 18'(house_ma)};
        row.typed = typed;
        row.fixed = fixed;
        directed_rows.push_back(row);
    endfunction

    // Receiver: ready pattern changes style after each span of random length.
    initial
    begin
        int style;
        int span;
        status_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
            repeat (span)
            begin
                @(posedge clk);
                case (style)
                    0: status_ch.ready <= 1'b1;
                    1: status_ch.ready <= 1'($urandom_range(0, 1));
                    2: status_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: status_ch.ready <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            got_status = status_t'{status_ch.charger_enable, status_ch.slow_charge,
                                   status_ch.ctrl_state, status_ch.selector_both,
                                   status_ch.fully_charged};
            if (status_due.size() == 0)
            begin
                status_errors++;
                if (status_errors <= 10)
                    $display("unrequested result en=%b slow=%b state=%0d both=%b full=%b",
                             got_status.charger_enable, got_status.slow_charge,
                             got_status.ctrl_state, got_status.selector_both,
                             got_status.fully_charged);
            end
            else
            begin
                want_status = status_due.pop_front();
                if (got_status !== want_status)
                begin
                    status_errors++;
                    if (status_errors <= 10)
                        $display({"mismatch: want en=%b slow=%b state=%0d both=%b full=%b,",
                                  " got en=%b slow=%b state=%0d both=%b full=%b"},
                                 want_status.charger_enable, want_status.slow_charge,
                                 want_status.ctrl_state, want_status.selector_both,
                                 want_status.fully_charged,
                                 got_status.charger_enable, got_status.slow_charge,
                                 got_status.ctrl_state, got_status.selector_both,
                                 got_status.fully_charged);
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        tick_ch.valid                 <= 1'b0;
        tick_ch.now_ms                <= '0;
        tick_ch.charge_mode           <= MODE_DISABLED;
        tick_ch.alternator_current_ma <= '0;
        tick_ch.starter_mv            <= '0;
        tick_ch.house_mv              <= '0;
        tick_ch.house_current_ma      <= '0;

        // Defaults after reset: 30 s holdoff, 12.2 V threshold, 14.4 V full.
        add_row(32'd0, MODE_AUTO, 0, 12000, 13000, 0, 1'b1,
                status_t'{1'b0, 1'b0, CTRL_IDLE, 1'b0, 1'b0});
        add_row(32'd1000, MODE_AUTO, 131071, 12500, 12000, 0, 1'b1,
                status_t'{1'b0, 1'b0, CTRL_ALT_ON, 1'b0, 1'b0});
        add_row(32'd20000, MODE_AUTO, 5000, 12500, 12000, 0);
        // Holdoff expires exactly at its delay.
        add_row(32'd31000, MODE_AUTO, 5000, 12500, 12000, 0, 1'b1,
                status_t'{1'b1, 1'b0, CTRL_CHARGING, 1'b0, 1'b0});
        add_row(32'd32000, MODE_AUTO, 5000, 11000, 12000, -3000);
        add_row(32'd40000, MODE_AUTO, 5000, 13000, 12000, -3000);
        add_row(32'd340000, MODE_AUTO, 5000, 13000, 12000, -3000);
        // Joined banks during a charge: selector only after the grace period.
        add_row(32'd341000, MODE_AUTO, 5000, 13000, 13050, -3000);
        add_row(32'd351000, MODE_AUTO, 5000, 13000, 13050, -3000);
        add_row(32'd351001, MODE_AUTO, 5000, 13000, 13050, -3000);
        add_row(32'd352000, MODE_AUTO, 5000, 14401, 14401, -3000);
        add_row(32'd353000, MODE_AUTO, 5000, 14401, 14401, -3000);
        add_row(32'd354000, MODE_FORCED_SLOW, 5000, 14000, 12000, -131072);
        add_row(32'd355000, MODE_UNUSED, -131072, 14000, 12000, 0);
        add_row(32'd356000, MODE_DISABLED, 5000, 14000, 12000, 0);
        add_row(32'd357000, MODE_AUTO, 1001, 0, 32767, 131071);
        // Joined banks while waiting for the holdoff drop back to idle.
        add_row(32'd358000, MODE_AUTO, 1001, 12000, 12050, 0);
        add_row(32'd359000, MODE_AUTO, 1000, 32767, 0, 0);
        // Holdoff across the wrap of the millisecond counter.
        add_row(32'hFFFF_F000, MODE_AUTO, 5000, 12500, 12000, 0);
        add_row(32'h0000_5000, MODE_AUTO, 5000, 12500, 12000, 0);
        add_row(32'h0000_7000, MODE_AUTO, 5000, 12500, 13500, -5000);
        add_row(32'h0000_7400, MODE_AUTO, 5000, 12500, 13500, -4999);
        add_row(32'h0000_8000, MODE_DISABLED, 5000, 12500, 13500, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].fixed);
        settle();

        gen_now = 32'd400000;
        load_settings(100, 12200, 300, 14400, 30, 1'b0);
        run_phase(190);

        gen_now = 32'hFFFD_0000;
        load_settings(0, 0, 0, 0, 0, 1'b1);
        run_phase(190);

        load_settings(4095, 32767, 4095, 32767, 4095, 1'b1);
        run_phase(150);

        repeat (3)
        begin
            load_settings($urandom_range(20, 400), $urandom_range(11000, 13500),
                          $urandom_range(0, 800), $urandom_range(13000, 15000),
                          $urandom_range(0, 60), 1'b1);
            run_phase(200);
        end

        repeat (10) @(posedge clk);
        if (status_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
